// File: design/rau_pkg.sv
package rau_pkg;

    localparam int FIELD_WIDTH_DEF = 32;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_NORM = 4'd4;
    localparam logic [3:0] OP_CMP  = 4'd5;
    localparam logic [3:0] OP_INC  = 4'd6;
    localparam logic [3:0] OP_DEC  = 4'd7;
    localparam logic [3:0] OP_NEG  = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
    } rau_out_t;

    // Start and operands of one 64-bit division pass.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } rau_div_req_t;

endpackage

// File: design/rational_arithmetic_unit.sv
// Rational arithmetic unit. Each request carries an opcode and two rationals
// and returns one reduced result with the sign in the numerator, compare flags
// and a status. Work runs on one shared multiplier for the cross products and
// one shared 64-bit shift-subtract divider under a small sequencer: the gcd is
// found by Euclid's remainder loop, one division per step (at most about 92
// steps for 64-bit operands, typically a few dozen; a zero numerator skips the
// loop), and the two quotients by the gcd take two more divisions. Compare,
// unused opcodes and zero denominators skip the divider and pass from the
// combine step straight to the output state. The block takes one request at a
// time and is ready again as soon as the result sits in the output register; a
// result still waiting there only holds back the handoff of the next one.
module rational_arithmetic_unit #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rau_pkg::rau_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rau_pkg::rau_out_t m_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_COMB  = 3'd3;
    localparam logic [2:0] S_GCD   = 3'd4;
    localparam logic [2:0] S_DIVN  = 3'd5;
    localparam logic [2:0] S_DIVD  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [63:0] HALF  = 64'd1 << (FIELD_WIDTH - 1);
    localparam logic [63:0] WMASK = (64'd1 << FIELD_WIDTH) - 64'd1;

    logic [2:0]  state_reg, state_next;
    logic        busy_div;
    rau_pkg::rau_in_t in_reg, in_next;
    // Sign-magnitude operands and products.
    logic        an_s, ad_s, bn_s;
    logic [32:0] an_m, ad_m, bn_m, bd_m;
    logic        p1_s_reg, p1_s_next, p2_s_reg, p2_s_next;
    logic [63:0] p1_m_reg, p1_m_next, p2_m_reg, p2_m_next;
    logic        n_s_reg, n_s_next, d_s_reg, d_s_next;
    logic [63:0] n_m_reg, n_m_next, d_m_reg, d_m_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;
    logic [63:0] num_reg, num_next;
    logic [32:0] ma, mb;
    logic        ma_s, mb_s;
    logic [65:0] prod;
    rau_pkg::rau_out_t res_reg, res_next;
    rau_pkg::rau_out_t out_reg, out_next;
    logic        mv_reg, mv_next;
    rau_pkg::rau_div_req_t dreq;
    logic        ddone;
    logic [63:0] dq, dr;
    logic [63:0] v;
    logic        neg, ovf;

    function automatic logic [32:0] mag33(input logic [31:0] x);
        mag33 = x[31] ? (33'h100000000 - {1'b0, x}) : {1'b0, x};
    endfunction

    assign an_s = in_reg.a_num[31];
    assign ad_s = in_reg.a_den[31];
    assign bn_s = in_reg.b_num[31];
    assign an_m = mag33(in_reg.a_num);
    assign ad_m = mag33(in_reg.a_den);
    assign bn_m = mag33(in_reg.b_num);
    assign bd_m = {2'b00, in_reg.b_den};

    // One shared multiplier; operand choice follows state and opcode.
    always_comb begin
        ma = an_m; mb = bd_m; ma_s = an_s; mb_s = 1'b0;
        case (in_reg.opcode)
            rau_pkg::OP_MUL: begin
                if (state_reg == S_MUL1) begin
                    mb = bn_m; mb_s = bn_s;
                end else begin
                    ma = ad_m; ma_s = ad_s;
                end
            end
            rau_pkg::OP_DIV: begin
                if (state_reg == S_MUL2) begin
                    ma = ad_m; ma_s = ad_s; mb = bn_m; mb_s = bn_s;
                end
            end
            default: begin
                if (state_reg == S_MUL2) begin
                    ma = bn_m; ma_s = bn_s; mb = ad_m; mb_s = ad_s;
                end else if (state_reg == S_COMB) begin
                    // The combine step forms the denominator of a sum.
                    ma = ad_m; ma_s = ad_s;
                end
            end
        endcase
    end
    assign prod = ma * mb;

    rau_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .done    (ddone),
        .quot    (dq),
        .rem     (dr)
    );

    assign neg = n_s_reg != d_s_reg && num_reg != 64'd0;
    assign ovf = (neg ? (num_reg > HALF) : (num_reg > HALF - 64'd1)) ||
                 (dq > HALF - 64'd1);
    always_comb begin
        v = (neg ? (64'd0 - num_reg) : num_reg) & WMASK;
        if ((v & HALF) != 64'd0) begin
            v = v | ~WMASK;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        in_next    = in_reg;
        p1_s_next  = p1_s_reg; p1_m_next = p1_m_reg;
        p2_s_next  = p2_s_reg; p2_m_next = p2_m_reg;
        n_s_next   = n_s_reg;  n_m_next  = n_m_reg;
        d_s_next   = d_s_reg;  d_m_next  = d_m_reg;
        x_next     = x_reg;    y_next    = y_reg;
        num_next   = num_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        mv_next    = mv_reg;
        dreq       = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next    = s_data;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                p1_m_next  = prod[63:0];
                p1_s_next  = (ma_s != mb_s) && prod[63:0] != 64'd0;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                p2_m_next  = prod[63:0];
                p2_s_next  = (ma_s != mb_s) && prod[63:0] != 64'd0;
                state_next = S_COMB;
            end
            S_COMB: begin
                // Form numerator and denominator in sign-magnitude.
                res_next = '0;
                d_s_next = ad_s; d_m_next = {31'd0, ad_m};
                case (in_reg.opcode)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        if ((p1_s_reg == (p2_s_reg ^ (in_reg.opcode == rau_pkg::OP_SUB)))
                            || p2_m_reg == 64'd0) begin
                            n_s_next = p1_s_reg;
                            n_m_next = p1_m_reg + p2_m_reg;
                        end else if (p1_m_reg >= p2_m_reg) begin
                            n_s_next = p1_s_reg;
                            n_m_next = p1_m_reg - p2_m_reg;
                        end else begin
                            n_s_next = !p1_s_reg;
                            n_m_next = p2_m_reg - p1_m_reg;
                        end
                        d_s_next = ad_s;
                        d_m_next = prod[63:0];
                    end
                    rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
                        n_s_next = p1_s_reg; n_m_next = p1_m_reg;
                        d_s_next = p2_s_reg; d_m_next = p2_m_reg;
                    end
                    rau_pkg::OP_NORM: begin
                        n_s_next = an_s; n_m_next = {31'd0, an_m};
                    end
                    rau_pkg::OP_NEG: begin
                        n_s_next = !an_s; n_m_next = {31'd0, an_m};
                    end
                    rau_pkg::OP_INC, rau_pkg::OP_DEC: begin
                        if ((an_s == (ad_s ^ (in_reg.opcode == rau_pkg::OP_DEC)))
                            || an_m == 33'd0) begin
                            n_s_next = (an_m == 33'd0) ?
                                (ad_s ^ (in_reg.opcode == rau_pkg::OP_DEC)) : an_s;
                            n_m_next = {31'd0, an_m} + {31'd0, ad_m};
                        end else if (an_m >= ad_m) begin
                            n_s_next = an_s; n_m_next = {31'd0, an_m - ad_m};
                        end else begin
                            n_s_next = !an_s; n_m_next = {31'd0, ad_m - an_m};
                        end
                    end
                    default: begin
                        n_s_next = 1'b0; n_m_next = '0;
                    end
                endcase
                if (in_reg.opcode == rau_pkg::OP_CMP) begin
                    if (p1_s_reg != p2_s_reg) begin
                        res_next.is_less = p1_s_reg;
                    end else if (p1_s_reg) begin
                        res_next.is_less = p1_m_reg > p2_m_reg;
                    end else begin
                        res_next.is_less = p1_m_reg < p2_m_reg;
                    end
                    res_next.is_equal = (in_reg.a_num == in_reg.b_num) &&
                                        (in_reg.a_den == {1'b0, in_reg.b_den});
                    state_next = S_OUT;
                end else if (in_reg.opcode > rau_pkg::OP_NEG) begin
                    state_next = S_OUT;
                end else if (d_m_next == 64'd0) begin
                    res_next.status = rau_pkg::ST_DIVZ;
                    state_next      = S_OUT;
                end else begin
                    y_next = d_m_next;
                    dreq = '{start: 1'b1, dividend: n_m_next, divisor: d_m_next};
                    if (n_m_next == 64'd0) begin
                        // Zero numerator: gcd is the denominator itself.
                        x_next     = d_m_next;
                        state_next = S_DIVN;
                    end else begin
                        x_next     = n_m_next;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (ddone) begin
                    if (dr == 64'd0) begin
                        // y is the gcd.
                        x_next = y_reg;
                        dreq = '{start: 1'b1, dividend: n_m_reg, divisor: y_reg};
                        state_next = S_DIVN;
                    end else begin
                        x_next = y_reg;
                        y_next = dr;
                        dreq = '{start: 1'b1, dividend: y_reg, divisor: dr};
                    end
                end
            end
            S_DIVN: begin
                if (ddone) begin
                    num_next = dq;
                    dreq = '{start: 1'b1, dividend: d_m_reg, divisor: x_reg};
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                if (ddone) begin
                    res_next.res_num  = v[31:0];
                    res_next.res_den  = 31'(dq & (HALF - 64'd1));
                    res_next.status   = ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    out_next   = res_reg;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // States in which the divider may be running.
    assign busy_div = (state_reg == S_GCD) || (state_reg == S_DIVN) ||
                      (state_reg == S_DIVD);

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        p1_s_reg <= p1_s_next; p1_m_reg <= p1_m_next;
        p2_s_reg <= p2_s_next; p2_m_reg <= p2_m_next;
        n_s_reg  <= n_s_next;  n_m_reg  <= n_m_next;
        d_s_reg  <= d_s_next;  d_m_reg  <= d_m_next;
        x_reg    <= x_next;    y_reg    <= y_next;
        num_reg  <= num_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_div_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ddone |-> busy_div)
        else $error("divider finished outside a division state");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GCD) |-> (d_m_reg != 64'd0))
        else $error("gcd started with zero denominator");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(out_reg))
        else $error("result changed while stalled");

endmodule

// File: design/rau_divider.sv
// Restoring divider: one quotient bit per cycle.
module rau_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rau_pkg::rau_div_req_t req,
    output logic                  done,
    output logic [63:0]           quot,
    output logic [63:0]           rem
);

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic [63:0] q_step;
    logic [63:0] r_step;

    assign shifted = {r_reg, q_reg[63]};
    assign diff    = shifted - {1'b0, d_reg};

    // Result of the current shift-subtract step, independent of a new start.
    assign q_step = {q_reg[62:0], !diff[64]};
    assign r_step = diff[64] ? shifted[63:0] : diff[63:0];

    // One shift-subtract step per cycle while busy.
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start) begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = r_step;
            q_next   = q_step;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign done = busy_reg && (cnt_reg == 7'd63);
    assign quot = q_step;
    assign rem  = r_step;

endmodule
